### rtl/mcad_pkg.sv
// ----------------------------------------------------------------------------
// mcad_pkg
// Shared widths, codes, register indexes and types of the delay line.
// ----------------------------------------------------------------------------
package mcad_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int TAG_W      = 16;
   localparam int RATE_W     = 20;
   localparam int MCHAN_W    = 8;
   localparam int CHAN_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int CC_W       = 4;
   localparam int DLEN_W     = 13;
   localparam int XRATE_W    = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;
   localparam int FILL_W     = 7;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int MAX_DELAY_DEF    = 4096;
   localparam int MAX_MESSAGE_DEF  = 64;

   // messages held between front and back
   localparam int JOB_LIMIT = 2;
   localparam int JOB_CNT_W = $clog2(JOB_LIMIT + 1);

   localparam logic [SAMPLE_W-2:0] UNIT_MAGNITUDE = 31'h3F80_0000;

   localparam logic [CC_W-1:0]    CHANNEL_COUNT_RESET = 4'd2;
   localparam logic [DLEN_W-1:0]  DELAY_LENGTH_RESET  = 13'd480;
   localparam logic [XRATE_W-1:0] EXPECTED_RATE_RESET = 19'd48000;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EXPECTED_RATE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_SAMPLE     = 2'd0,
      ST_BAD_SAMPLE = 2'd1,
      ST_FORMAT     = 2'd2,
      ST_LENGTH     = 2'd3
   } status_type;

   typedef struct packed {
      logic [CC_W-1:0]    channel_count;
      logic [DLEN_W-1:0]  delay_length;
      logic [XRATE_W-1:0] expected_rate;
   } cfg_type;

   typedef struct packed {
      status_type        code;
      logic [FILL_W-1:0] fill;
      logic [TAG_W-1:0]  tag;
      logic              bank;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/mcad_intf.sv
// ----------------------------------------------------------------------------
// mcad_intf
// Request, response and register write channels of the delay line.
// ----------------------------------------------------------------------------
interface mcad_req_if import mcad_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [SAMPLE_W-1:0]  sample_word;
   logic [TAG_W-1:0]     source_tag;
   logic [RATE_W-1:0]    message_rate;
   logic [MCHAN_W-1:0]   message_channels;
   logic                 last_in_message;

   modport source (output valid, sample_word, source_tag, message_rate, message_channels,
                   last_in_message, input ready);
   modport sink (input valid, sample_word, source_tag, message_rate, message_channels,
                 last_in_message, output ready);
endinterface

interface mcad_rsp_if import mcad_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [SAMPLE_W-1:0]  delayed_word;
   logic [CHAN_W-1:0]    sample_lane;
   logic [STATUS_W-1:0]  status;
   logic                 source_changed;
   logic                 last_result;

   modport source (output valid, delayed_word, sample_lane, status, source_changed,
                   last_result, input ready);
   modport sink (input valid, delayed_word, sample_lane, status, source_changed,
                 last_result, output ready);
endinterface

interface mcad_csr_if import mcad_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/mcad_ram.sv
// ----------------------------------------------------------------------------
// mcad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcad_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mcad_queue.sv
// ----------------------------------------------------------------------------
// mcad_queue
// Small FIFO of checked messages between the front and the back.
// ----------------------------------------------------------------------------
module mcad_queue import mcad_pkg::*; #(
   parameter  int DEPTH = JOB_LIMIT,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push   = push && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (int'(count_ff) == DEPTH);
   assign status.empty = (count_ff == '0);

endmodule

### rtl/mcad_front.sv
// ----------------------------------------------------------------------------
// mcad_front
// Takes sample requests, stores them in the message buffer and checks format,
// length and sample range; at the last request it queues the message.
// ----------------------------------------------------------------------------
module mcad_front import mcad_pkg::*; #(
   parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter  int MAX_MESSAGE  = MAX_MESSAGE_DEF,
   localparam int MSG_IW       = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                enable,
   input  queue_status_type    qstat,
   mcad_req_if.sink            req_ch,
   output logic                msg_wr_en,
   output logic [MSG_IW:0]     msg_wr_addr,
   output logic [SAMPLE_W-1:0] msg_wr_data,
   output logic                job_push,
   output job_type             job_new
);

   logic [FILL_W-1:0] fill_ff, fill_in, fill_cnt;
   logic [CC_W-1:0]   phase_ff, phase_in, phase_cnt, phase_next;
   status_type        err_ff, err_in, err_a, err_b, err_c, code;
   logic              bank_ff, bank_in;
   logic              accept, cc_ok, fmt_bad, store, bad_sample;

   assign req_ch.ready = enable && !qstat.full;

   always_comb begin
      accept     = req_ch.valid && req_ch.ready;
      cc_ok      = (cfg.channel_count != '0) && (int'(cfg.channel_count) <= MAX_CHANNELS);
      fmt_bad    = !cc_ok
                   || (MCHAN_W'(cfg.channel_count) != req_ch.message_channels)
                   || (RATE_W'(cfg.expected_rate) != req_ch.message_rate);
      store      = int'(fill_ff) < MAX_MESSAGE;
      bad_sample = req_ch.sample_word[SAMPLE_W-2:0] > UNIT_MAGNITUDE;

      // priority: format, then length, then sample range
      err_a = fmt_bad ? ST_FORMAT : err_ff;
      err_b = (!store && err_a != ST_FORMAT) ? ST_LENGTH : err_a;
      err_c = (bad_sample && err_b == ST_SAMPLE) ? ST_BAD_SAMPLE : err_b;

      phase_next = phase_ff + CC_W'(1);
      phase_cnt  = phase_ff;
      fill_cnt   = fill_ff;
      if (store) begin
         phase_cnt = (phase_next == cfg.channel_count) ? '0 : phase_next;
         fill_cnt  = fill_ff + FILL_W'(1);
      end

      code = (err_c == ST_FORMAT) ? ST_FORMAT
           : (phase_cnt != '0)    ? ST_LENGTH
           : err_c;

      fill_in  = fill_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (req_ch.last_in_message) begin
            fill_in  = '0;
            phase_in = '0;
            err_in   = ST_SAMPLE;
            bank_in  = !bank_ff;
         end else begin
            fill_in  = fill_cnt;
            phase_in = phase_cnt;
            err_in   = err_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         phase_ff <= '0;
         err_ff   <= ST_SAMPLE;
         bank_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
         bank_ff  <= bank_in;
      end
   end

   assign msg_wr_en    = accept && store;
   assign msg_wr_addr  = {bank_ff, fill_ff[MSG_IW-1:0]};
   assign msg_wr_data  = req_ch.sample_word;
   assign job_push     = accept && req_ch.last_in_message;
   assign job_new.code = code;
   assign job_new.fill = fill_cnt;
   assign job_new.tag  = req_ch.source_tag;
   assign job_new.bank = bank_ff;

endmodule

### rtl/mcad_back.sv
// ----------------------------------------------------------------------------
// mcad_back
// Replays a queued message through the per-channel delay rings and drives
// the response register; emits a single drop status for failed messages.
// ----------------------------------------------------------------------------
module mcad_back import mcad_pkg::*; #(
   parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter  int MAX_DELAY    = MAX_DELAY_DEF,
   parameter  int MAX_MESSAGE  = MAX_MESSAGE_DEF,
   localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int POS_W        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1,
   localparam int MSG_IW       = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   forget,
   input  queue_status_type       qstat,
   input  job_type                job_head,
   output logic                   job_pop,
   output logic                   msg_rd_en,
   output logic [MSG_IW:0]        msg_rd_addr,
   input  logic [SAMPLE_W-1:0]    msg_rd_data,
   output logic                   dly_rd_en,
   output logic [CH_W+POS_W-1:0]  dly_rd_addr,
   input  logic [SAMPLE_W-1:0]    dly_rd_data,
   output logic                   dly_wr_en,
   output logic [CH_W+POS_W-1:0]  dly_wr_addr,
   output logic [SAMPLE_W-1:0]    dly_wr_data,
   output logic                   job_done,
   mcad_rsp_if.source             rsp_ch
);

   localparam int LEN_W = $clog2(MAX_DELAY + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_WRITE = 4'b0100,
      S_DROP  = 4'b1000
   } back_state_type;

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic [FILL_W-1:0]   idx_ff, idx_in, idx_next;
   logic [CH_W-1:0]     chan_ff, chan_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    written_ff, written_in;
   logic [LEN_W-1:0]    len_eff, pos_next;
   logic [TAG_W-1:0]    src_ff, src_in;
   logic                known_ff, known_in;
   logic                changed_ff, changed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] word_ff, word_in;
   logic [CHAN_W-1:0]   ochan_ff, ochan_in;
   status_type          status_ff, status_in;
   logic                ochanged_ff, ochanged_in;
   logic                olast_ff, olast_in;
   logic                out_free, load, new_src, frame_end, last_item;

   always_comb begin
      if (cfg.delay_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (int'(cfg.delay_length) > MAX_DELAY) begin
         len_eff = LEN_W'(MAX_DELAY);
      end else begin
         len_eff = LEN_W'(cfg.delay_length);
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ch.ready;
      new_src   = !known_ff || (job_head.tag != src_ff);
      idx_next  = idx_ff + FILL_W'(1);
      last_item = (idx_next == job_ff.fill);
      frame_end = (int'(chan_ff) == int'(cfg.channel_count) - 1);
      pos_next  = LEN_W'(pos_ff) + LEN_W'(1);

      state_in    = state_ff;
      job_in      = job_ff;
      idx_in      = idx_ff;
      chan_in     = chan_ff;
      pos_in      = pos_ff;
      written_in  = written_ff;
      src_in      = src_ff;
      known_in    = known_ff;
      changed_in  = changed_ff;
      job_pop     = 1'b0;
      job_done    = 1'b0;
      msg_rd_en   = 1'b0;
      dly_rd_en   = 1'b0;
      dly_wr_en   = 1'b0;
      load        = 1'b0;
      word_in     = word_ff;
      ochan_in    = ochan_ff;
      status_in   = status_ff;
      ochanged_in = ochanged_ff;
      olast_in    = olast_ff;

      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               job_pop = 1'b1;
               job_in  = job_head;
               idx_in  = '0;
               chan_in = '0;
               if (job_head.code != ST_SAMPLE) begin
                  state_in = S_DROP;
               end else begin
                  state_in   = S_READ;
                  changed_in = known_ff && (job_head.tag != src_ff);
                  if (new_src) begin
                     written_in = '0;
                     pos_in     = '0;
                     src_in     = job_head.tag;
                     known_in   = 1'b1;
                  end else if (LEN_W'(pos_ff) >= len_eff) begin
                     pos_in = '0;
                  end
               end
            end
         end
         S_READ: begin
            msg_rd_en = 1'b1;
            dly_rd_en = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               dly_wr_en   = 1'b1;
               load        = 1'b1;
               // entries not written since the last clear read as silence
               word_in     = (LEN_W'(pos_ff) < written_ff) ? dly_rd_data : '0;
               ochan_in    = CHAN_W'(chan_ff);
               status_in   = ST_SAMPLE;
               ochanged_in = changed_ff;
               olast_in    = last_item;
               idx_in      = idx_next;
               if (frame_end) begin
                  chan_in    = '0;
                  pos_in     = (pos_next >= len_eff) ? '0 : POS_W'(pos_next);
                  written_in = (written_ff < len_eff) ? written_ff + LEN_W'(1) : written_ff;
               end else begin
                  chan_in = chan_ff + CH_W'(1);
               end
               if (last_item) begin
                  job_done = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_DROP: begin
            if (out_free) begin
               load        = 1'b1;
               word_in     = '0;
               ochan_in    = '0;
               status_in   = job_ff.code;
               ochanged_in = 1'b0;
               olast_in    = 1'b1;
               job_done    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (forget) begin
         known_in = 1'b0;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         chan_ff      <= '0;
         pos_ff       <= '0;
         written_ff   <= '0;
         src_ff       <= '0;
         known_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chan_ff      <= chan_in;
         pos_ff       <= pos_in;
         written_ff   <= written_in;
         src_ff       <= src_in;
         known_ff     <= known_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      word_ff     <= word_in;
      ochan_ff    <= ochan_in;
      status_ff   <= status_in;
      ochanged_ff <= ochanged_in;
      olast_ff    <= olast_in;
   end

   assign msg_rd_addr = {job_ff.bank, idx_ff[MSG_IW-1:0]};
   assign dly_rd_addr = {chan_ff, pos_ff};
   assign dly_wr_addr = {chan_ff, pos_ff};
   assign dly_wr_data = msg_rd_data;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.delayed_word   = word_ff;
   assign rsp_ch.sample_lane    = ochan_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.source_changed = ochanged_ff;
   assign rsp_ch.last_result    = olast_ff;

endmodule

### rtl/multichannel_audio_delay_line.sv
// ----------------------------------------------------------------------------
// multichannel_audio_delay_line
// Per-channel fixed delay for interleaved float audio messages.
// ----------------------------------------------------------------------------
// req_ch carries one sample word per request with the message header fields;
// last_in_message closes a message. rsp_ch returns one delayed sample per
// stored word, in input order, or a single drop status for a failed message.
// csr_ch writes channel_count, delay_length and expected_rate; it is always
// ready. The user must write it only while no message is in flight; the
// block does not enforce this. Requests stall only while two complete
// messages are waiting for or in replay (the message buffer is double-banked).
// The last request queues the message; the back pops it, then for each stored
// word reads the delay memory, then writes back the new sample and loads the
// response register. A failed message loads its drop status after the pop.
// Reset restores the register defaults and empties the delay rings: a count
// of frames written since the last clear makes unwritten entries read as
// zero, so no clearing pass runs. When rsp_ch.ready is low the response
// register holds and replay pauses; the request side keeps filling the
// other buffer bank.
// ----------------------------------------------------------------------------
module multichannel_audio_delay_line import mcad_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_DELAY    = MAX_DELAY_DEF,
   parameter int MAX_MESSAGE  = MAX_MESSAGE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcad_req_if.sink   req_ch,
   mcad_rsp_if.source rsp_ch,
   mcad_csr_if.sink   csr_ch
);

   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int POS_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int MSG_IW    = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
   localparam int MSG_DEPTH = 1 << (MSG_IW + 1);
   localparam int DLY_DEPTH = 1 << (CH_W + POS_W);

   cfg_type                cfg_ff, cfg_in;
   logic [JOB_CNT_W-1:0]   jobs_ff, jobs_in;
   logic                   csr_wr, forget, front_enable;
   logic                   job_push, job_pop, job_done;
   job_type                job_new, job_head;
   queue_status_type       qstat;
   logic                   msg_wr_en, msg_rd_en;
   logic [MSG_IW:0]        msg_wr_addr, msg_rd_addr;
   logic [SAMPLE_W-1:0]    msg_wr_data, msg_rd_data;
   logic                   dly_wr_en, dly_rd_en;
   logic [CH_W+POS_W-1:0]  dly_wr_addr, dly_rd_addr;
   logic [SAMPLE_W-1:0]    dly_wr_data, dly_rd_data;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      csr_wr = csr_ch.valid && csr_ch.ready;
      cfg_in = cfg_ff;
      forget = 1'b0;
      if (csr_wr) begin
         case (csr_ch.index)
            REG_CHANNEL_COUNT: begin
               cfg_in.channel_count = csr_ch.data[CC_W-1:0];
               forget = 1'b1;
            end
            REG_DELAY_LENGTH: begin
               cfg_in.delay_length = csr_ch.data[DLEN_W-1:0];
               forget = 1'b1;
            end
            REG_EXPECTED_RATE: begin
               cfg_in.expected_rate = csr_ch.data[XRATE_W-1:0];
            end
            default: ;
         endcase
      end

      jobs_in = jobs_ff;
      if (job_push && !job_done) begin
         jobs_in = jobs_ff + JOB_CNT_W'(1);
      end else if (!job_push && job_done) begin
         jobs_in = jobs_ff - JOB_CNT_W'(1);
      end
      front_enable = int'(jobs_ff) < JOB_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CHANNEL_COUNT_RESET;
         cfg_ff.delay_length  <= DELAY_LENGTH_RESET;
         cfg_ff.expected_rate <= EXPECTED_RATE_RESET;
         jobs_ff              <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         jobs_ff <= jobs_in;
      end
   end

   mcad_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_MESSAGE  (MAX_MESSAGE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .enable      (front_enable),
      .qstat       (qstat),
      .req_ch      (req_ch),
      .msg_wr_en   (msg_wr_en),
      .msg_wr_addr (msg_wr_addr),
      .msg_wr_data (msg_wr_data),
      .job_push    (job_push),
      .job_new     (job_new)
   );

   mcad_queue #(
      .DEPTH (JOB_LIMIT)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_new),
      .pop      (job_pop),
      .head_job (job_head),
      .status   (qstat)
   );

   mcad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MSG_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_wr_en),
      .wr_addr (msg_wr_addr),
      .wr_data (msg_wr_data),
      .rd_en   (msg_rd_en),
      .rd_addr (msg_rd_addr),
      .rd_data (msg_rd_data)
   );

   mcad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DLY_DEPTH)
   ) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_wr_en),
      .wr_addr (dly_wr_addr),
      .wr_data (dly_wr_data),
      .rd_en   (dly_rd_en),
      .rd_addr (dly_rd_addr),
      .rd_data (dly_rd_data)
   );

   mcad_back #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DELAY    (MAX_DELAY),
      .MAX_MESSAGE  (MAX_MESSAGE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .forget      (forget),
      .qstat       (qstat),
      .job_head    (job_head),
      .job_pop     (job_pop),
      .msg_rd_en   (msg_rd_en),
      .msg_rd_addr (msg_rd_addr),
      .msg_rd_data (msg_rd_data),
      .dly_rd_en   (dly_rd_en),
      .dly_rd_addr (dly_rd_addr),
      .dly_rd_data (dly_rd_data),
      .dly_wr_en   (dly_wr_en),
      .dly_wr_addr (dly_wr_addr),
      .dly_wr_data (dly_wr_data),
      .job_done    (job_done),
      .rsp_ch      (rsp_ch)
   );

`ifndef ASSERT_OFF
   a_jobs_bound: assert property (@(posedge clock) disable iff (reset)
      int'(jobs_ff) <= JOB_LIMIT)
      else $error("more messages pending than buffer banks");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !qstat.full)
      else $error("message queued while queue full");

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      job_done |-> (jobs_ff != '0))
      else $error("replay finished with no message pending");

   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_SAMPLE) |->
         (rsp_ch.last_result && rsp_ch.delayed_word == '0 && !rsp_ch.source_changed))
      else $error("drop response not a single cleared result");
`endif

endmodule
